FILE: rtl/dbt_pkg.sv
// shared types, constants and table functions for the waypoint distance, bearing and turn pipeline
package dbt_pkg;

	localparam int CORDIC_STAGES       = 16;
	localparam int ANGLE_FRACTION_BITS = 7;

	// internal angle unit is 2^-INNER_BITS degree
	localparam int INNER_BITS     = 16;
	localparam int PRESCALE_SHIFT = 14;
	localparam int TABLE_LEN      = 24;

	// one root bit per step, 17 root bits cover a 34-bit radicand
	localparam int SQRT_STEPS = 17;
	localparam int CHAIN_LEN  = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
	localparam int IDX_W      = $clog2(CHAIN_LEN);

	// datapath widths
	localparam int XW = 34;
	localparam int ZW = 26;
	localparam int RW = 34;

	localparam int HALF_ANG    = 180 << ANGLE_FRACTION_BITS;
	localparam int FULL_ANG    = 360 << ANGLE_FRACTION_BITS;
	localparam int ANG_W_MIN   = $clog2(FULL_ANG) + 3;
	localparam int ANG_W       = (ANG_W_MIN > 19) ? ANG_W_MIN : 19;
	localparam int ROUND_SHIFT = INNER_BITS - ANGLE_FRACTION_BITS;

	// number of restoring steps that bring a 16-bit offset heading below one turn
	function automatic int calc_head_steps(input int full);
		int n;
		n = 0;
		while ((full << n) <= 65535)
			n++;
		return n;
	endfunction

	localparam int HEAD_STEPS = calc_head_steps(FULL_ANG);
	// heading offset by 32768, plus this, is congruent to the heading
	localparam int HEAD_OFF   = ((-32768 % FULL_ANG) + FULL_ANG) % FULL_ANG;

	localparam logic signed [ANG_W-1:0] HALF_W = ANG_W'(HALF_ANG);
	localparam logic signed [ANG_W-1:0] FULL_W = ANG_W'(FULL_ANG);
	localparam logic signed [ZW-1:0]    Z_QUARTER = ZW'(90 << INNER_BITS);
	localparam logic [15:0]             DIST_MAX  = 16'hFFFF;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic [RW-1:0]        rem;
		logic [RW-1:0]        root;
		logic [15:0]          hred;
		logic signed [15:0]   head;
		logic                 zero;
	} step_t;

	// atan(2^-i) in 2^-16 degree, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_entry(input logic [IDX_W-1:0] i);
		logic signed [ZW-1:0] v;
		unique case (int'(i))
			0:       v = ZW'(2949120);
			1:       v = ZW'(1740967);
			2:       v = ZW'(919879);
			3:       v = ZW'(466945);
			4:       v = ZW'(234379);
			5:       v = ZW'(117304);
			6:       v = ZW'(58666);
			7:       v = ZW'(29335);
			8:       v = ZW'(14668);
			9:       v = ZW'(7334);
			10:      v = ZW'(3667);
			11:      v = ZW'(1833);
			12:      v = ZW'(917);
			13:      v = ZW'(458);
			14:      v = ZW'(229);
			15:      v = ZW'(115);
			16:      v = ZW'(57);
			17:      v = ZW'(29);
			18:      v = ZW'(14);
			19:      v = ZW'(7);
			20:      v = ZW'(4);
			21:      v = ZW'(2);
			22:      v = ZW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic cordic_en(input logic [IDX_W-1:0] i);
		return (int'(i) < CORDIC_STAGES) && (int'(i) < TABLE_LEN);
	endfunction

	// trial bit of the root step, zero where the step does no root work
	function automatic logic [RW-1:0] sqrt_bit(input logic [IDX_W-1:0] i);
		logic [RW-1:0] b;
		b = '0;
		if (int'(i) < SQRT_STEPS)
			b[2 * (SQRT_STEPS - 1 - int'(i))] = 1'b1;
		return b;
	endfunction

	function automatic logic head_en(input logic [IDX_W-1:0] i);
		return int'(i) < HEAD_STEPS;
	endfunction

	function automatic logic [15:0] head_thr(input logic [IDX_W-1:0] i);
		logic [31:0] t;
		t = '0;
		if (int'(i) < HEAD_STEPS)
			t = 32'(FULL_ANG) << (HEAD_STEPS - 1 - int'(i));
		return t[15:0];
	endfunction

endpackage

FILE: rtl/dbt_front.sv
// front end: differences, squares, quadrant pre-rotation and radicand sum
module dbt_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  logic [15:0]         robot_x,
	input  logic [15:0]         robot_y,
	input  logic [15:0]         target_x,
	input  logic [15:0]         target_y,
	input  logic signed [15:0]  robot_heading,
	output logic                out_vld,
	output dbt_pkg::step_t      out_d
);

	logic                            vld_s1, vld_s2, vld_s3;
	logic signed [16:0]              dx_s1, dy_s1;
	logic signed [15:0]              head_s1, head_s2;
	logic [31:0]                     sqx_s2, sqy_s2;
	logic signed [dbt_pkg::XW-1:0]   x_s2, y_s2;
	logic signed [dbt_pkg::ZW-1:0]   z_s2;
	logic                            zero_s2;
	dbt_pkg::step_t                  d_s3;

	logic signed [16:0]              dx, dy;
	logic signed [33:0]              px, py;
	logic signed [dbt_pkg::XW-1:0]   xi, yi, xr, yr;
	logic signed [dbt_pkg::ZW-1:0]   zr;

	assign dx = $signed({1'b0, target_x}) - $signed({1'b0, robot_x});
	assign dy = $signed({1'b0, target_y}) - $signed({1'b0, robot_y});

	assign px = dx_s1 * dx_s1;
	assign py = dy_s1 * dy_s1;

	// fold the left half plane onto the right by a quarter turn
	always_comb begin
		xi = dbt_pkg::XW'(dx_s1) <<< dbt_pkg::PRESCALE_SHIFT;
		yi = dbt_pkg::XW'(dy_s1) <<< dbt_pkg::PRESCALE_SHIFT;
		xr = xi;
		yr = yi;
		zr = '0;
		if (xi < 0) begin
			if (yi >= 0) begin
				xr = yi;
				yr = -xi;
				zr = dbt_pkg::Z_QUARTER;
			end else begin
				xr = -yi;
				yr = xi;
				zr = -dbt_pkg::Z_QUARTER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= dx;
		dy_s1   <= dy;
		head_s1 <= robot_heading;

		sqx_s2  <= px[31:0];
		sqy_s2  <= py[31:0];
		x_s2    <= xr;
		y_s2    <= yr;
		z_s2    <= zr;
		zero_s2 <= (dx_s1 == '0) && (dy_s1 == '0);
		head_s2 <= head_s1;

		d_s3.x    <= x_s2;
		d_s3.y    <= y_s2;
		d_s3.z    <= z_s2;
		d_s3.rem  <= dbt_pkg::RW'(sqx_s2) + dbt_pkg::RW'(sqy_s2);
		d_s3.root <= '0;
		// heading plus 32768, kept unsigned for the reduction steps
		d_s3.hred <= {~head_s2[15], head_s2[14:0]};
		d_s3.head <= head_s2;
		d_s3.zero <= zero_s2;
	end

	assign out_vld = vld_s3;
	assign out_d   = d_s3;

endmodule

FILE: rtl/dbt_step.sv
// one pipeline step: a cordic micro-rotation, a root bit and a heading reduction step
module dbt_step (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [dbt_pkg::IDX_W-1:0]   idx,
	input  logic                        in_vld,
	input  dbt_pkg::step_t              in_d,
	output logic                        out_vld,
	output dbt_pkg::step_t              out_d
);

	logic                            vld_s1;
	dbt_pkg::step_t                  d_s1;
	dbt_pkg::step_t                  nxt;
	logic signed [dbt_pkg::XW-1:0]   xv, yv, xs, ys;
	logic [dbt_pkg::RW-1:0]          sbit, trial;
	logic [15:0]                     thr;

	always_comb begin
		nxt   = in_d;
		xv    = in_d.x;
		yv    = in_d.y;
		xs    = xv >>> idx;
		ys    = yv >>> idx;
		sbit  = dbt_pkg::sqrt_bit(idx);
		trial = in_d.root + sbit;
		thr   = dbt_pkg::head_thr(idx);

		// drive y toward zero
		if (dbt_pkg::cordic_en(idx)) begin
			if (yv >= 0) begin
				nxt.x = xv + ys;
				nxt.y = yv - xs;
				nxt.z = in_d.z + dbt_pkg::atan_entry(idx);
			end else begin
				nxt.x = xv - ys;
				nxt.y = yv + xs;
				nxt.z = in_d.z - dbt_pkg::atan_entry(idx);
			end
		end

		if (sbit != '0) begin
			if (in_d.rem >= trial) begin
				nxt.rem  = in_d.rem - trial;
				nxt.root = (in_d.root >> 1) + sbit;
			end else begin
				nxt.root = in_d.root >> 1;
			end
		end

		if (dbt_pkg::head_en(idx) && (in_d.hred >= thr))
			nxt.hred = in_d.hred - thr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		d_s1 <= nxt;
	end

	assign out_vld = vld_s1;
	assign out_d   = d_s1;

endmodule

FILE: rtl/dbt_back.sv
// back end: angle rounding, wrapping, turn angle and distance saturation
module dbt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  dbt_pkg::step_t      in_d,
	output logic                done,
	output logic [15:0]         distance_out,
	output logic signed [15:0]  bearing,
	output logic signed [15:0]  turn_angle,
	output logic                turn_right
);

	logic                              vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [dbt_pkg::ANG_W-1:0]  bear_s1, bear_s2, bear_s3, bear_s4;
	logic signed [dbt_pkg::ANG_W-1:0]  hm_s1, hm_s2;
	logic signed [15:0]                head_s1, head_s2;
	logic [15:0]                       dist_s1, dist_s2, dist_s3, dist_s4;
	logic signed [dbt_pkg::ANG_W-1:0]  ap_s3;
	logic                              agt_s3;
	logic signed [dbt_pkg::ANG_W-1:0]  turn_s4;
	logic                              right_s4;

	logic signed [dbt_pkg::ZW:0]       negz, rnd, shifted;
	logic signed [dbt_pkg::ANG_W-1:0]  bear_raw, hm, bear_w, turn;

	// negate, round half up into the output unit, and bring the reduced heading below one turn
	always_comb begin
		negz     = -{in_d.z[dbt_pkg::ZW-1], in_d.z};
		rnd      = negz + (dbt_pkg::ZW + 1)'(1 << (dbt_pkg::ROUND_SHIFT - 1));
		shifted  = rnd >>> dbt_pkg::ROUND_SHIFT;
		bear_raw = in_d.zero ? '0 : dbt_pkg::ANG_W'(shifted);
		hm       = dbt_pkg::ANG_W'({1'b0, in_d.hred}) + dbt_pkg::ANG_W'(dbt_pkg::HEAD_OFF);
		if (hm >= dbt_pkg::FULL_W)
			hm = hm - dbt_pkg::FULL_W;
	end

	always_comb begin
		bear_w = bear_s1;
		if (bear_s1 > dbt_pkg::HALF_W)
			bear_w = bear_s1 - dbt_pkg::FULL_W;
		else if (bear_s1 < -dbt_pkg::HALF_W)
			bear_w = bear_s1 + dbt_pkg::FULL_W;
	end

	// exact half turn keeps the sign of the unwrapped difference
	always_comb begin
		turn = ap_s3;
		if (ap_s3 < -dbt_pkg::HALF_W)
			turn = ap_s3 + dbt_pkg::FULL_W;
		else if (ap_s3 > dbt_pkg::HALF_W)
			turn = ap_s3 - dbt_pkg::FULL_W;
		if ((turn == dbt_pkg::HALF_W) || (turn == -dbt_pkg::HALF_W))
			turn = agt_s3 ? dbt_pkg::HALF_W : -dbt_pkg::HALF_W;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		bear_s1 <= bear_raw;
		hm_s1   <= hm;
		head_s1 <= in_d.head;
		dist_s1 <= (in_d.root[dbt_pkg::RW-1:16] != '0) ? dbt_pkg::DIST_MAX : in_d.root[15:0];

		bear_s2 <= bear_w;
		hm_s2   <= hm_s1;
		head_s2 <= head_s1;
		dist_s2 <= dist_s1;

		ap_s3   <= bear_s2 - hm_s2;
		agt_s3  <= bear_s2 > dbt_pkg::ANG_W'(head_s2);
		bear_s3 <= bear_s2;
		dist_s3 <= dist_s2;

		turn_s4  <= turn;
		right_s4 <= turn <= 0;
		bear_s4  <= bear_s3;
		dist_s4  <= dist_s3;
	end

	assign done         = vld_s4;
	assign distance_out = dist_s4;
	assign bearing      = bear_s4[15:0];
	assign turn_angle   = turn_s4[15:0];
	assign turn_right   = right_s4;

	a_heading_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (hm_s1 >= 0) && (hm_s1 < dbt_pkg::FULL_W))
		else $error("reduced heading outside one turn");

	a_bearing_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (bear_s2 >= -dbt_pkg::HALF_W) && (bear_s2 <= dbt_pkg::HALF_W))
		else $error("wrapped bearing out of range");

	a_turn_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (turn_s4 >= -dbt_pkg::HALF_W) && (turn_s4 <= dbt_pkg::HALF_W))
		else $error("turn angle out of range");

endmodule

FILE: rtl/waypoint_distance_bearing_turn.sv
// top level of the waypoint distance, bearing and turn pipeline
// throughput: one item per cycle, set by the fully pipelined cordic and root-step chain
// busy is held low; done marks each result for exactly one cycle, one result per transfer
// reset (arst_n low) clears every valid bit at once, items in flight are dropped
module waypoint_distance_bearing_turn (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [15:0]         robot_x,
	input  logic [15:0]         robot_y,
	input  logic [15:0]         target_x,
	input  logic [15:0]         target_y,
	input  logic signed [15:0]  robot_heading,
	output logic                done,
	output logic [15:0]         distance_out,
	output logic signed [15:0]  bearing,
	output logic signed [15:0]  turn_angle,
	output logic                turn_right
);

	// accepted transfer enters the front end directly
	logic               accept;

	// chain taps: entry k feeds step k, the last entry feeds the back end
	logic               chain_vld [0:dbt_pkg::CHAIN_LEN];
	dbt_pkg::step_t     chain_d   [0:dbt_pkg::CHAIN_LEN];

	// every stage advances each cycle, so the block never pushes back
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// differences, squares, quarter-turn fold and radicand
	dbt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_vld        (accept),
		.robot_x       (robot_x),
		.robot_y       (robot_y),
		.target_x      (target_x),
		.target_y      (target_y),
		.robot_heading (robot_heading),
		.out_vld       (chain_vld[0]),
		.out_d         (chain_d[0])
	);

	// one register stage per micro-rotation and root bit; the heading
	// is reduced modulo one turn in the first of the same stages
	for (genvar k = 0; k < dbt_pkg::CHAIN_LEN; k++) begin : g_step
		dbt_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (dbt_pkg::IDX_W'(k)),
			.in_vld  (chain_vld[k]),
			.in_d    (chain_d[k]),
			.out_vld (chain_vld[k + 1]),
			.out_d   (chain_d[k + 1])
		);
	end

	// rounding, wrap, turn angle and output registers
	dbt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_vld       (chain_vld[dbt_pkg::CHAIN_LEN]),
		.in_d         (chain_d[dbt_pkg::CHAIN_LEN]),
		.done         (done),
		.distance_out (distance_out),
		.bearing      (bearing),
		.turn_angle   (turn_angle),
		.turn_right   (turn_right)
	);

endmodule
